### rtl/pspa_pkg.sv
// pspa_pkg: shared types and constants of the polar step position accumulator.
// No dependencies; imported by every rtl module of the block.
`timescale 1ns / 1ps

package pspa_pkg;

    localparam int FRAC_BITS = 8;
    localparam logic [30:0] TARGET_RESET = 31'(100 << FRAC_BITS);

    // 1/gain in Q0.30, split in two 15-bit halves for the shared multiplier
    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam logic [14:0] GAIN_LO = INV_GAIN[14:0];
    localparam logic [14:0] GAIN_HI = INV_GAIN[29:15];

    // one queued step: length, half-turn fold flag, folded binary angle
    typedef struct packed {
        logic [15:0]        len;
        logic               neg;
        logic signed [31:0] ang;
    } step_item_t;

    function automatic logic [31:0] atan_at(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

### rtl/polar_step_position_accumulator_unit.sv
// polar_step_position_accumulator_unit: top level; target register, front queue
// and CORDIC back end. Uses pspa_pkg, pspa_front, pspa_back.
//
//  channel  | signals                                | transfer when
//  ---------+----------------------------------------+---------------------
//  input    | push, full, step_length, step_heading  | push && !full
//  result   | empty, pop, pos_*_out, distance_out... | pop && !empty
//  config   | cfg_valid, cfg_ready, cfg_data         | cfg_valid && cfg_ready
//
// Each step is processed in the shared CORDIC unit and its 38x16
// multiplier; the two-entry front queue takes steps while the back end
// works. A finished result waits in the output register; the back end
// holds in its last state until that register frees.
// Reset clears position, step count and queue; target returns to 100.0.
`timescale 1ns / 1ps

module polar_step_position_accumulator_unit
    import pspa_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        step_length,
    input  logic [8:0]         step_heading,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] pos_x_out,
    output logic signed [31:0] pos_y_out,
    output logic [30:0]        distance_out,
    output logic signed [15:0] bearing_out,
    output logic [15:0]        steps_taken,
    output logic               reached,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data
);

    logic [30:0] target_reg;
    logic        item_valid;
    logic        item_take;
    step_item_t  item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= TARGET_RESET;
        else if (cfg_valid && cfg_ready)
            target_reg <= cfg_data;
    end

    pspa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .step_length  (step_length),
        .step_heading (step_heading),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    pspa_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .target       (target_reg),
        .empty        (empty),
        .pop          (pop),
        .pos_x_out    (pos_x_out),
        .pos_y_out    (pos_y_out),
        .distance_out (distance_out),
        .bearing_out  (bearing_out),
        .steps_taken  (steps_taken),
        .reached      (reached)
    );

endmodule

### rtl/pspa_front.sv
// pspa_front: input side; reduces the heading, converts it to a binary angle,
// folds it into the right half plane and queues the step. Uses pspa_pkg.
`timescale 1ns / 1ps

module pspa_front
    import pspa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] step_length,
    input  logic [8:0]  step_heading,
    output logic        item_valid,
    output step_item_t  item,
    input  logic        item_take
);

    logic [8:0]  h;
    logic [16:0] v;
    logic [13:0] w;
    logic [28:0] qprod;
    logic [32:0] base;
    logic [31:0] ang;
    logic signed [31:0] zs;
    step_item_t  new_item;

    step_item_t  q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    // 2^32 = 360*11930464 + 256, so the angle is h*11930464 + (256h+180)/360
    always_comb
    begin
        h = (step_heading >= 9'd360) ? 9'(step_heading - 9'd360) : step_heading;
        v = 17'({h, 8'd0}) + 17'd180;
        w = v[16:3];
        qprod = 29'(w * 15'd23302);       // /45 by reciprocal, exact for w below 2^14
        base = 33'(h * 24'd11930464);
        ang = base[31:0] + 32'(qprod[28:20]);
        zs = $signed(ang);
        new_item.len = step_length;
        if (zs > 32'sh40000000)
        begin
            new_item.neg = 1'b1;
            new_item.ang = zs ^ 32'sh80000000;
        end
        else if (zs < -32'sh40000000)
        begin
            new_item.neg = 1'b1;
            new_item.ang = zs ^ 32'sh80000000;
        end
        else
        begin
            new_item.neg = 1'b0;
            new_item.ang = zs;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign do_pop     = item_take && item_valid;
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, do_push} - {1'b0, do_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

### rtl/pspa_back.sv
// pspa_back: shared CORDIC sequencer (rotate, scale, accumulate, vector,
// scale) and the result register. Uses pspa_pkg.
`timescale 1ns / 1ps

module pspa_back
    import pspa_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  step_item_t         item,
    output logic               item_take,
    input  logic [30:0]        target,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] pos_x_out,
    output logic signed [31:0] pos_y_out,
    output logic [30:0]        distance_out,
    output logic signed [15:0] bearing_out,
    output logic [15:0]        steps_taken,
    output logic               reached
);

    localparam int IW = $clog2(CORDIC_ITERATIONS);
    localparam logic [IW-1:0] LAST = IW'(CORDIC_ITERATIONS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ROT, S_MUL, S_ACC, S_VEC, S_DMUL, S_DONE
    } state_t;

    state_t             state_reg;
    logic [IW-1:0]      iter_reg;
    logic [1:0]         ph_reg;
    logic signed [37:0] x_reg, y_reg;
    logic signed [35:0] z_reg;
    logic signed [69:0] acc_reg;
    logic signed [33:0] dx_reg, dy_reg;
    logic signed [31:0] posx_reg, posy_reg;
    logic [15:0]        cnt_reg;
    logic               zero_reg;
    logic [30:0]        dist_reg;
    logic signed [15:0] bear_reg;
    logic               out_valid_reg;

    logic signed [37:0] sx, sy, mul_src, px, py, tz;
    logic signed [35:0] at;
    logic [14:0]        coef;
    logic signed [53:0] prod;
    logic signed [69:0] term, sum, rnd44;
    logic [69:0]        rnd32;
    logic signed [34:0] sumx, sumy;
    logic signed [31:0] satx, saty;
    logic signed [37:0] bsum;
    logic signed [15:0] bear;
    logic [30:0]        dist_sat;
    logic               out_free;

    assign sx = x_reg >>> iter_reg;
    assign sy = y_reg >>> iter_reg;
    assign at = $signed({4'd0, atan_at(5'(iter_reg))});

    // one 38x16 multiplier; each product is half of the 30-bit gain
    always_comb
    begin
        mul_src = (state_reg == S_MUL && ph_reg[1]) ? y_reg : x_reg;
        coef    = ph_reg[0] ? GAIN_HI : GAIN_LO;
        prod    = mul_src * $signed({1'b0, coef});
        term    = ph_reg[0] ? (70'(prod) <<< 15) : 70'(prod);
        sum     = ph_reg[0] ? acc_reg + term : term;
        rnd44   = (sum + (70'sd1 <<< 43)) >>> 44;
        rnd32   = ($unsigned(sum) + 70'h80000000) >> 32;
        dist_sat = (rnd32 > 70'h7FFFFFFF) ? 31'h7FFFFFFF : rnd32[30:0];
    end

    always_comb
    begin
        sumx = 35'(posx_reg) + 35'(dx_reg);
        sumy = 35'(posy_reg) + 35'(dy_reg);
        if (sumx > 35'sh7FFFFFFF)
            satx = 32'sh7FFFFFFF;
        else if (sumx < -35'sh80000000)
            satx = 32'sh80000000;
        else
            satx = sumx[31:0];
        if (sumy > 35'sh7FFFFFFF)
            saty = 32'sh7FFFFFFF;
        else if (sumy < -35'sh80000000)
            saty = 32'sh80000000;
        else
            saty = sumy[31:0];
        px = satx[31] ? -38'(satx) : 38'(satx);
        py = satx[31] ? -38'(saty) : 38'(saty);
    end

    // degrees Q9.7 = round(angle * 45 / 2^22); the 45*2^31 bias is a multiple of 2^22
    always_comb
    begin
        tz   = 38'($signed(z_reg[31:0])) * 38'sd45;
        bsum = tz + (38'sd1 <<< 21);
        bear = bsum[37:22];
        if (bear == -16'sd23040 && !posy_reg[31])
            bear = 16'sd23040;
    end

    assign out_free  = !out_valid_reg || pop;
    assign item_take = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            ph_reg        <= 2'd0;
            posx_reg      <= '0;
            posy_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        x_reg     <= item.neg ? -38'({item.len, 14'd0})
                                              : 38'({item.len, 14'd0});
                        y_reg     <= '0;
                        z_reg     <= 36'(item.ang);
                        iter_reg  <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    if (!z_reg[35])
                    begin
                        x_reg <= x_reg - sy;
                        y_reg <= y_reg + sx;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + sy;
                        y_reg <= y_reg - sx;
                        z_reg <= z_reg + at;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == LAST)
                    begin
                        ph_reg    <= 2'd0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    acc_reg <= sum;
                    ph_reg  <= ph_reg + 2'd1;
                    if (ph_reg == 2'd1)
                        dx_reg <= rnd44[33:0];
                    if (ph_reg == 2'd3)
                    begin
                        dy_reg    <= rnd44[33:0];
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    posx_reg <= satx;
                    posy_reg <= saty;
                    if (cnt_reg != 16'hFFFF)
                        cnt_reg <= cnt_reg + 16'd1;
                    zero_reg <= (satx == 32'sd0) && (saty == 32'sd0);
                    x_reg    <= px <<< 2;
                    y_reg    <= py <<< 2;
                    z_reg    <= satx[31] ? 36'sh080000000 : 36'sd0;
                    iter_reg <= '0;
                    state_reg <= S_VEC;
                end
                S_VEC:
                begin
                    if (y_reg[37])
                    begin
                        x_reg <= x_reg - sy;
                        y_reg <= y_reg + sx;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + sy;
                        y_reg <= y_reg - sx;
                        z_reg <= z_reg + at;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == LAST)
                    begin
                        ph_reg    <= 2'd0;
                        state_reg <= S_DMUL;
                    end
                end
                S_DMUL:
                begin
                    acc_reg <= sum;
                    ph_reg  <= ph_reg + 2'd1;
                    if (ph_reg == 2'd1)
                    begin
                        dist_reg  <= zero_reg ? 31'd0 : dist_sat;
                        bear_reg  <= zero_reg ? 16'sd0 : bear;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        pos_x_out     <= posx_reg;
                        pos_y_out     <= posy_reg;
                        distance_out  <= dist_reg;
                        bearing_out   <= bear_reg;
                        steps_taken   <= cnt_reg;
                        reached       <= (dist_reg >= target);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty = !out_valid_reg;

    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        iter_reg <= LAST)
        else $error("iteration count out of range");

    a_vec_x_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DMUL |-> !x_reg[37])
        else $error("vectoring x went negative");

    a_steps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> steps_taken != 16'd0)
        else $error("result with zero step count");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> state_reg == S_IDLE && out_valid_reg)
        else $error("finished result not transferred to output");

endmodule
